@@ rtl/core/qtav_pkg.sv @@
// ----------------------------------------------------------------------------
// qtav_pkg
// shared types and constants of the quaternion to axis vectors unit
// ----------------------------------------------------------------------------
`default_nettype none

package qtav_pkg;

  localparam int unsigned CompW  = 16;
  localparam int unsigned ProdW  = 2 * CompW;
  localparam int unsigned SumW   = ProdW + 1;
  localparam int unsigned NumW   = ProdW + 3;
  localparam int unsigned NLanes = 6;

  localparam logic signed [CompW-1:0] SatMax = 16'sh7fff;
  localparam logic signed [CompW-1:0] SatMin = 16'sh8000;

  typedef logic [SumW-1:0] qtav_mag_t;

  typedef struct packed {
    logic signed [CompW-1:0] quat_x;
    logic signed [CompW-1:0] quat_y;
    logic signed [CompW-1:0] quat_z;
    logic signed [CompW-1:0] quat_w;
  } qtav_in_t;

  typedef struct packed {
    logic                    valid_res;
    logic signed [CompW-1:0] trans_x;
    logic signed [CompW-1:0] trans_y;
    logic signed [CompW-1:0] trans_z;
    logic signed [CompW-1:0] norm_x;
    logic signed [CompW-1:0] norm_y;
    logic signed [CompW-1:0] norm_z;
  } qtav_out_t;

  typedef struct packed {
    logic              valid;
    logic              ok;
    logic [NLanes-1:0] neg;
  } qtav_side_t;

endpackage

`default_nettype wire

@@ rtl/core/qtav_div_pipe.sv @@
// ----------------------------------------------------------------------------
// qtav_div_pipe
// six-lane restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
`default_nettype none

module qtav_div_pipe import qtav_pkg::*; #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire qtav_side_t            side_i,
  input  wire qtav_mag_t             s_i,
  input  wire qtav_mag_t             mag_i [NLanes],
  output qtav_side_t                 side_o,
  output logic [FRAC_BITS+1:0]       quo_o [NLanes]
);

  localparam int unsigned QW    = FRAC_BITS + 2;
  localparam int unsigned NStep = FRAC_BITS + 2;

  qtav_side_t       side_q [NStep];
  qtav_mag_t        s_q    [NStep];
  qtav_mag_t        rem_q  [NStep][NLanes];
  logic [QW-1:0]    quo_q  [NStep][NLanes];
  qtav_mag_t        rem_d  [NStep][NLanes];
  logic [QW-1:0]    quo_d  [NStep][NLanes];

  for (genvar k = 0; k < NStep; k++) begin : g_step
    qtav_side_t side_src;
    qtav_mag_t  s_src;

    if (k == 0) begin : g_first
      assign side_src = side_i;
      assign s_src    = s_i;
    end else begin : g_next
      assign side_src = side_q[k-1];
      assign s_src    = s_q[k-1];
    end

    for (genvar l = 0; l < NLanes; l++) begin : g_lane
      logic [SumW:0]  trial;
      logic [QW-1:0]  qprev;
      logic           qbit;

      if (k == 0) begin : g_first
        assign trial = {1'b0, mag_i[l]};
        assign qprev = '0;
      end else begin : g_next
        assign trial = {rem_q[k-1][l], 1'b0};
        assign qprev = quo_q[k-1][l];
      end

      assign qbit        = trial >= {1'b0, s_src};
      assign rem_d[k][l] = qbit ? SumW'(trial - {1'b0, s_src}) : trial[SumW-1:0];
      assign quo_d[k][l] = {qprev[QW-2:0], qbit};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k] <= '0;
      end else if (en_i) begin
        side_q[k] <= side_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k] <= s_src;
        for (int l = 0; l < NLanes; l++) begin
          rem_q[k][l] <= rem_d[k][l];
          quo_q[k][l] <= quo_d[k][l];
        end
      end
    end
  end

  assign side_o = side_q[NStep-1];
  assign quo_o  = quo_q[NStep-1];

  logic quo_in_range;

  always_comb begin
    quo_in_range = 1'b1;
    for (int l = 0; l < NLanes; l++) begin
      if (quo_o[l] > (QW)'(1) << (FRAC_BITS + 1)) begin
        quo_in_range = 1'b0;
      end
    end
  end

  a_quo_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_o.valid && side_o.ok |-> quo_in_range)
    else $error("quotient exceeds unit range");

  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_q[0].valid && side_q[0].ok |-> rem_q[0][0] < s_q[0])
    else $error("partial remainder not below divisor");

  a_adv_only_en : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(side_o))
    else $error("divider moved while stalled");

endmodule

`default_nettype wire

@@ rtl/core/quaternion_to_axis_vectors_unit.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_axis_vectors_unit
// quaternion to first and third rotation matrix columns, q1.14, saturated
// ----------------------------------------------------------------------------
// Takes one quaternion item per cycle while no result is held at the output
// and returns one result item per input through one product stage, one sum
// stage, FRAC_BITS + 2 restoring divide stages (one quotient bit each, six
// lanes) and the output register. The whole pipeline holds while a result
// waits at the output. Inputs whose squared magnitude is zero or below
// min_magnitude squared give valid_res = 0 and zero vectors. The floor
// register resets to 2 and should be written only while the unit is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_axis_vectors_unit import qtav_pkg::*; #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire qtav_in_t   in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output qtav_out_t       out_o
);

  localparam int unsigned QW = FRAC_BITS + 2;
  localparam int unsigned CW = (QW > 17) ? QW : 17;

  logic en;
  logic [15:0] min_mag_q;

  // stage 1: products
  logic                    v1_q;
  logic signed [ProdW-1:0] xx_q, yy_q, zz_q, ww_q, xy_q, zw_q, xz_q, yw_q, yz_q, xw_q;
  logic [ProdW-1:0]        floor2_q;

  // stage 2: sums and magnitudes
  qtav_side_t side2_d, side2_q;
  qtav_mag_t  s2_d, s2_q;
  qtav_mag_t  mag2_d [NLanes];
  qtav_mag_t  mag2_q [NLanes];

  logic signed [NumW-1:0] sx, sy, sz, sw, pxy, pzw, pxz, pyw, pyz, pxw, ssum;
  logic signed [NumW-1:0] num [NLanes];

  qtav_side_t        side_div;
  logic [QW-1:0]     quo_div [NLanes];
  logic signed [15:0] res [NLanes];

  qtav_out_t out_d, out_q;
  logic      out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mag_q <= 16'd2;
    end else if (cfg_we_i) begin
      min_mag_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      side2_q <= '0;
    end else if (en) begin
      v1_q    <= in_valid_i;
      side2_q <= side2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q     <= in_i.quat_x * in_i.quat_x;
      yy_q     <= in_i.quat_y * in_i.quat_y;
      zz_q     <= in_i.quat_z * in_i.quat_z;
      ww_q     <= in_i.quat_w * in_i.quat_w;
      xy_q     <= in_i.quat_x * in_i.quat_y;
      zw_q     <= in_i.quat_z * in_i.quat_w;
      xz_q     <= in_i.quat_x * in_i.quat_z;
      yw_q     <= in_i.quat_y * in_i.quat_w;
      yz_q     <= in_i.quat_y * in_i.quat_z;
      xw_q     <= in_i.quat_x * in_i.quat_w;
      floor2_q <= min_mag_q * min_mag_q;
      s2_q     <= s2_d;
      mag2_q   <= mag2_d;
    end
  end

  always_comb begin
    sx   = NumW'(xx_q);
    sy   = NumW'(yy_q);
    sz   = NumW'(zz_q);
    sw   = NumW'(ww_q);
    pxy  = NumW'(xy_q);
    pzw  = NumW'(zw_q);
    pxz  = NumW'(xz_q);
    pyw  = NumW'(yw_q);
    pyz  = NumW'(yz_q);
    pxw  = NumW'(xw_q);
    ssum = (sx + sy) + (sz + sw);
    num[0] = (sx + sw) - (sy + sz);
    num[1] = (pxy + pzw) <<< 1;
    num[2] = (pxz - pyw) <<< 1;
    num[3] = (pxz + pyw) <<< 1;
    num[4] = (pyz - pxw) <<< 1;
    num[5] = (sz + sw) - (sx + sy);
    s2_d          = ssum[SumW-1:0];
    side2_d.valid = v1_q;
    side2_d.ok    = (s2_d != '0) && (s2_d >= {1'b0, floor2_q});
    for (int l = 0; l < NLanes; l++) begin
      side2_d.neg[l] = num[l][NumW-1];
      mag2_d[l]      = num[l][NumW-1] ? SumW'(-num[l]) : num[l][SumW-1:0];
    end
  end

  qtav_div_pipe #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .side_i(side2_q),
    .s_i   (s2_q),
    .mag_i (mag2_q),
    .side_o(side_div),
    .quo_o (quo_div)
  );

  // round half up on the extra quotient bit, then saturate
  for (genvar l = 0; l < NLanes; l++) begin : g_sat
    logic [QW:0]   rsum;
    logic [CW-1:0] qx;

    assign rsum = {1'b0, quo_div[l]} + (QW + 1)'(1);
    assign qx   = CW'(rsum[QW:1]);

    always_comb begin
      if (!side_div.ok) begin
        res[l] = '0;
      end else if (side_div.neg[l]) begin
        res[l] = (qx > CW'(32768)) ? SatMin : -$signed(qx[15:0]);
      end else begin
        res[l] = (qx > CW'(32767)) ? SatMax : $signed(qx[15:0]);
      end
    end
  end

  always_comb begin
    out_d.valid_res = side_div.ok;
    out_d.trans_x   = res[0];
    out_d.trans_y   = res[1];
    out_d.trans_z   = res[2];
    out_d.norm_x    = res[3];
    out_d.norm_y    = res[4];
    out_d.norm_z    = res[5];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= side_div.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.valid_res |-> out_o.trans_x == '0 && out_o.trans_y == '0 &&
      out_o.trans_z == '0 && out_o.norm_x == '0 && out_o.norm_y == '0 && out_o.norm_z == '0)
    else $error("invalid item carries nonzero vectors");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a held result");

  a_zero_sum_invalid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    side2_q.valid && s2_q == '0 |-> !side2_q.ok)
    else $error("zero quaternion flagged valid");

endmodule

`default_nettype wire

@@ sim/quaternion_to_axis_vectors_unit_tb.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_axis_vectors_unit_tb
// self-checking testbench of the quaternion to axis vectors unit
// ----------------------------------------------------------------------------
// Feeds directed and random quaternion items through a valid/ready driver,
// predicts each result item with a bit-accurate model of the normalized
// rotation matrix columns, and compares every field of every result item in
// order. The magnitude floor is set to several values, the extremes among
// them, while the unit is empty. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quaternion_to_axis_vectors_unit_tb;
  import qtav_pkg::*;

  localparam int unsigned FracBits   = 14;
  localparam int unsigned Latency    = FracBits + 5;
  localparam int unsigned CycleLimit = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  qtav_in_t  in_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  qtav_out_t out_o;

  quaternion_to_axis_vectors_unit #(.FRAC_BITS(FracBits)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
  );

  always #1 clk_i = ~clk_i;

  qtav_in_t   pending_quats[$];
  qtav_out_t  expected_axes[$];
  logic [15:0] floor_mag = 16'd2;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          idle_en = 1'b1;
  int unsigned hold_cycles = 0;

  function automatic logic [15:0] round_div(longint num, longint s);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< FracBits) * 2 + s) / (2 * s);
    if (num < 0) return (q > 32768) ? 16'h8000 : 16'(-q);
    return (q > 32767) ? 16'h7fff : 16'(q);
  endfunction

  function automatic qtav_out_t axes_of(qtav_in_t q);
    qtav_out_t r;
    longint x, y, z, w, xx, yy, zz, ww, s, fl;
    x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
    xx = x * x; yy = y * y; zz = z * z; ww = w * w;
    s = xx + yy + zz + ww;
    fl = longint'(floor_mag) * longint'(floor_mag);
    r = '0;
    if (s == 0 || s < fl) return r;
    r.valid_res = 1'b1;
    r.trans_x = round_div(s - 2 * (yy + zz), s);
    r.trans_y = round_div(2 * (x * y + z * w), s);
    r.trans_z = round_div(2 * (x * z - y * w), s);
    r.norm_x  = round_div(2 * (x * z + y * w), s);
    r.norm_y  = round_div(2 * (y * z - x * w), s);
    r.norm_z  = round_div(s - 2 * (xx + yy), s);
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (pending_quats.size() != 0 && !(idle_en && $urandom_range(99) < 21)) begin
          in_i <= pending_quats[0];
          expected_axes.push_back(axes_of(pending_quats[0]));
          void'(pending_quats.pop_front());
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_axes.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected result item %h", out_o);
        end else begin
          if (out_o !== expected_axes[0]) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: expected %h actual %h", expected_axes[0], out_o);
          end
          void'(expected_axes.pop_front());
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(idle_en && $urandom_range(99) < 21);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_quats.size() != 0 || in_valid_i || expected_axes.size() != 0)
      @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic set_floor(logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    floor_mag = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic qtav_in_t mk(int a, int b, int c, int d);
    qtav_in_t q;
    q.quat_x = 16'(a); q.quat_y = 16'(b); q.quat_z = 16'(c); q.quat_w = 16'(d);
    return q;
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(32)) - 16);
      2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic add_random(int n);
    qtav_in_t q;
    repeat (n) begin
      q.quat_x = rand_comp(); q.quat_y = rand_comp();
      q.quat_z = rand_comp(); q.quat_w = rand_comp();
      pending_quats.push_back(q);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed items at reset floor
    pending_quats.push_back(mk(0, 0, 0, 0));
    pending_quats.push_back(mk(0, 0, 0, 16384));
    pending_quats.push_back(mk(16384, 0, 0, 0));
    pending_quats.push_back(mk(0, 16384, 0, 0));
    pending_quats.push_back(mk(0, 0, 16384, 0));
    pending_quats.push_back(mk(1, 0, 0, 0));
    pending_quats.push_back(mk(1, 1, 1, 1));
    pending_quats.push_back(mk(2, 0, 0, 0));
    pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
    pending_quats.push_back(mk(32767, 32767, 32767, 32767));
    pending_quats.push_back(mk(-32768, 32767, -32768, 32767));
    pending_quats.push_back(mk(8192, 8192, 8192, 8192));
    pending_quats.push_back(mk(-1, 0, 0, 1));
    pending_quats.push_back(mk(3, -5, 7, -11));
    wait_drained();
    // zero floor: zero quaternion still invalid
    set_floor(16'd0);
    pending_quats.push_back(mk(0, 0, 0, 0));
    pending_quats.push_back(mk(0, 0, 0, -1));
    add_random(150);
    wait_drained();
    set_floor(16'hffff);
    pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
    pending_quats.push_back(mk(32767, 32767, 32767, 32767));
    add_random(100);
    wait_drained();
    set_floor(16'd16384);
    pending_quats.push_back(mk(16384, 0, 0, 0));
    pending_quats.push_back(mk(16383, 0, 0, 0));
    add_random(150);
    wait_drained();
    // long receiver hold while the sender keeps offering
    idle_en = 1'b0;
    set_floor(16'd100);
    hold_cycles = 200;
    add_random(150);
    wait_drained();
    set_floor(16'($urandom_range(40000)));
    add_random(150);
    wait_drained();
    idle_en = 1'b1;
    set_floor(16'd2);
    add_random(200);
    wait_drained();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/qtav_pkg.sv
rtl/core/qtav_div_pipe.sv
rtl/core/quaternion_to_axis_vectors_unit.sv
sim/quaternion_to_axis_vectors_unit_tb.sv
